FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the decimal ASCII converter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ITDA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next.
`define ITDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/itda_pkg.sv
// ----------------------------------------------------------------------------
// itda_pkg
// Types and constants shared by the decimal ASCII converter modules.
// ----------------------------------------------------------------------------
package itda_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 6;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int STEP_CNT_W = 4;   // 16 steps, two bits each
  localparam int LEFT_W     = 4;   // 1..10 digits

  localparam logic [CHAR_W-1:0]     CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0]     CHAR_ZERO  = 6'd48;
  localparam logic [STEP_CNT_W-1:0] LAST_STEP  = 4'd15;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_ALIGN,
    ST_EMIT
  } itda_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic step;
    logic align;
    logic emit;
  } itda_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic step_last;
    logic out_free;
    logic emit_last;
  } itda_sts_t;

endpackage

FILE: hw/rtl/itda_ctrl.sv
// ----------------------------------------------------------------------------
// itda_ctrl
// Sequencer: load, shift-add-3 conversion, alignment, character emission.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itda_ctrl
  import itda_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  itda_sts_t sts,
  output itda_cmd_t cmd
);

  itda_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        if (sts.step_last) begin
          state_next = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        cmd.align  = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // one item at a time: after an accepted transaction the input closes
  `ITDA_ASSERT_NEXT(a_busy_after_load, clk, rst, in_valid && in_ready, !in_ready,
    "input still open after accepting an item")
  `ITDA_ASSERT(a_one_cmd, clk, rst, $onehot0({cmd.load, cmd.step, cmd.align, cmd.emit}),
    "more than one datapath command at once")

endmodule

FILE: hw/rtl/itda_datapath.sv
// ----------------------------------------------------------------------------
// itda_datapath
// Magnitude and BCD registers, shift-add-3 unit, output character register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itda_datapath
  import itda_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [VALUE_W-1:0] value,
  input  itda_cmd_t          cmd,
  output itda_sts_t          sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAR_W-1:0]  out_char,
  output logic               out_last
);

  logic [VALUE_W-1:0]    mag;
  logic [BCD_W-1:0]      bcd;
  logic [STEP_CNT_W-1:0] step_cnt;
  logic [LEFT_W-1:0]     left;
  logic                  sign_pend;

  logic [VALUE_W-1:0] mag_step;
  logic [BCD_W-1:0]   bcd_step;
  logic [BCD_W-1:0]   bcd_align;
  logic [LEFT_W-1:0]  nd;

  function automatic logic [BCD_W-1:0] dd_adjust(input logic [BCD_W-1:0] b);
    logic [BCD_W-1:0] r;
    r = b;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (b[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = b[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  // two shift-add-3 iterations per cycle
  always_comb begin
    logic [BCD_W-1:0]   b;
    logic [VALUE_W-1:0] m;
    b = bcd;
    m = mag;
    for (int s = 0; s < 2; s++) begin
      b = dd_adjust(b);
      b = {b[BCD_W-2:0], m[VALUE_W-1]};
      m = {m[VALUE_W-2:0], 1'b0};
    end
    bcd_step = b;
    mag_step = m;
  end

  // digit count from the highest nonzero nibble; left-justify the digits
  always_comb begin
    logic [LEFT_W-1:0] lz;
    nd = LEFT_W'(1);
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        nd = LEFT_W'(i + 1);
      end
    end
    lz        = LEFT_W'(NUM_DIGITS) - nd;
    bcd_align = bcd << {lz, 2'b00};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag       <= value[VALUE_W-1] ? VALUE_W'(0 - value) : value;
      bcd       <= '0;
      step_cnt  <= '0;
      sign_pend <= value[VALUE_W-1];
    end
    if (cmd.step) begin
      mag      <= mag_step;
      bcd      <= bcd_step;
      step_cnt <= step_cnt + STEP_CNT_W'(1);
    end
    if (cmd.align) begin
      bcd  <= bcd_align;
      left <= nd;
    end
    if (cmd.emit) begin
      if (sign_pend) begin
        out_char  <= CHAR_MINUS;
        out_last  <= 1'b0;
        sign_pend <= 1'b0;
      end else begin
        out_char <= CHAR_ZERO + {2'b00, bcd[BCD_W-1 -: 4]};
        out_last <= (left == LEFT_W'(1));
        bcd      <= {bcd[BCD_W-5:0], 4'h0};
        left     <= left - LEFT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.step_last = (step_cnt == LAST_STEP);
  assign sts.out_free  = !out_valid || out_ready;
  assign sts.emit_last = !sign_pend && (left == LEFT_W'(1));

  `ITDA_ASSERT(a_char_range, clk, rst,
    !out_valid || out_char == CHAR_MINUS ||
    (out_char >= CHAR_ZERO && out_char <= CHAR_ZERO + 6'd9),
    "output character is neither minus nor a digit")
  `ITDA_ASSERT(a_left_nonzero, clk, rst, !(cmd.emit && !sign_pend) || left != '0,
    "digit emitted with no digits left")
  `ITDA_ASSERT_NEXT(a_last_flag, clk, rst, cmd.emit && sts.emit_last, out_valid && out_last,
    "final character not flagged last")

endmodule

FILE: hw/rtl/integer_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_core
// Signed 32-bit integer to decimal ASCII text, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one signed 32-bit value per transaction.
//   m_* channel returns its text one character per transaction: an optional
//   minus sign, then 1..10 digits without leading zeros; m_tlast marks the
//   final character. Zero yields a single '0'.
// Timing:
//   After acceptance the value runs through the shift-add-3 BCD loop (two
//   bits per cycle), an align step left-justifies the digits, then one
//   character per cycle enters the output register while m_tready allows.
//   The next value is accepted once the final character sits in the output
//   register, even if the receiver has not yet taken it.
// Reset: synchronous rst returns the sequencer to idle and empties the
//   output register. A stalled receiver holds the current character and
//   pauses emission; no character is dropped.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii_core
  import itda_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value (signed)
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [5:0] character, [7:6] zero
  output logic        m_tlast
);

  itda_cmd_t         cmd;
  itda_sts_t         sts;
  logic [CHAR_W-1:0] out_char;

  itda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  itda_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .value     (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (out_char),
    .out_last  (m_tlast)
  );

  assign m_tdata = {2'b00, out_char};

endmodule

FILE: verif/integer_to_decimal_ascii_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_checker
// Watches both stream channels of the converter and checks the text it emits.
// Each accepted value is turned into its decimal characters here and queued;
// every character taken on the output is compared with the oldest one queued.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii_checker
  import itda_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value (signed)
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // [5:0] character, [7:6] zero
  input  logic        m_tlast,
  input  logic        wrap_up,
  output int          fail_count,
  output int          pending,
  output int          values_seen,
  output int          chars_seen
);

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } text_char_t;

  text_char_t text_due[$];

  // Builds the decimal text of one value, sign first, digits MSD first.
  task automatic queue_decimal_text(input logic [VALUE_W-1:0] value);
    logic              negative;
    logic [VALUE_W-1:0] magnitude;
    logic [3:0]        digit_buf [NUM_DIGITS];
    int                ndig;
    text_char_t        tc;
    negative  = value[VALUE_W-1];
    // unsigned negate also covers the most negative value
    magnitude = negative ? (32'd0 - value) : value;
    ndig      = 0;
    do begin
      digit_buf[ndig] = 4'(magnitude % 10);
      magnitude       = magnitude / 10;
      ndig++;
    end while (magnitude != 0 && ndig < NUM_DIGITS);
    if (negative) begin
      tc.character = CHAR_MINUS;
      tc.last      = 1'b0;
      text_due.push_back(tc);
    end
    for (int k = ndig - 1; k >= 0; k--) begin
      tc.character = CHAR_ZERO + CHAR_W'(digit_buf[k]);
      tc.last      = (k == 0);
      text_due.push_back(tc);
    end
  endtask

  initial begin
    fail_count  = 0;
    pending     = 0;
    values_seen = 0;
    chars_seen  = 0;
  end

  always @(posedge clk) begin
    int         errs;
    text_char_t want;
    errs = 0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        queue_decimal_text(s_tdata);
        values_seen <= values_seen + 1;
      end
      if (m_tvalid && m_tready) begin
        chars_seen <= chars_seen + 1;
        if (text_due.size() == 0) begin
          $error("unexpected character transaction: character %0d last %0b",
                 m_tdata[CHAR_W-1:0], m_tlast);
          errs++;
        end else begin
          want = text_due.pop_front();
          if (m_tdata[CHAR_W-1:0] !== want.character) begin
            $error("character: expected %0d, got %0d", want.character,
                   m_tdata[CHAR_W-1:0]);
            errs++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, m_tlast);
            errs++;
          end
          if (m_tdata[7:CHAR_W] !== '0) begin
            $error("tdata pad: expected 0, got %0d", m_tdata[7:CHAR_W]);
            errs++;
          end
        end
      end
      if (wrap_up && text_due.size() != 0) begin
        $error("%0d characters never came out", text_due.size());
        errs += text_due.size();
        text_due.delete();
      end
    end
    fail_count <= fail_count + errs;
    pending    <= text_due.size();
  end

endmodule

FILE: verif/integer_to_decimal_ascii_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_core_test
// Drives signed values into the converter and lets the checker verify text.
// A directed set covers zero, single digits, decade edges and both extremes;
// then random values spread over every digit count and sign, sent in bursts
// with random gaps while the receiver stalls on changing patterns.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii_core_test;
  import itda_pkg::*;

  localparam int RANDOM_VALUES = 115;
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 40;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;   // [31:0] value (signed)
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // [5:0] character, [7:6] zero
  logic        m_tlast;
  logic        wrap_up  = 1'b0;

  int fail_count;
  int pending;
  int values_seen;
  int chars_seen;
  int idle_cycles = 0;
  logic [7:0] ready_phase = '0;

  always #1 clk = ~clk;

  integer_to_decimal_ascii_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  integer_to_decimal_ascii_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .wrap_up     (wrap_up),
    .fail_count  (fail_count),
    .pending     (pending),
    .values_seen (values_seen),
    .chars_seen  (chars_seen)
  );

  // Receiver: always ready, coin flip, mostly stalled, then a fixed rhythm.
  always @(posedge clk) begin
    ready_phase <= ready_phase + 1'b1;
    case (ready_phase[7:6])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= 1'($urandom_range(1, 0));
      2'd2: m_tready <= ($urandom_range(3, 0) == 0);
      default: m_tready <= ready_phase[2];
    endcase
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("integer_to_decimal_ascii_core_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Holds the value until the core takes it; returns on the accepting edge.
  task automatic send_value(input logic [31:0] value);
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic hold_off(input int cycles);
    s_tvalid <= 1'b0;
    s_tdata  <= $urandom;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_all_text();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Uniform over digit count first, so short and long texts both show up.
  function automatic logic [31:0] pick_value();
    int          ndig;
    int          pick;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mag;
    pick = $urandom_range(15, 0);
    if (pick == 0) return $urandom;
    if (pick == 1) return 32'h8000_0000;
    ndig = $urandom_range(NUM_DIGITS, 1);
    lo   = 32'd1;
    repeat (ndig - 1) lo = lo * 10;
    hi   = (ndig == NUM_DIGITS) ? 32'h7FFF_FFFF : lo * 10 - 1;
    mag  = $urandom_range(hi, lo);
    if (ndig == 1 && $urandom_range(3, 0) == 0) mag = '0;
    return $urandom_range(1, 0) ? (32'd0 - mag) : mag;
  endfunction

  initial begin
    logic [31:0] directed [];
    int burst_left;
    directed = '{
      32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      -32'sd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
      32'd1_000_000_000, 32'd999_999_999, -32'sd999_999_999,
      32'd1_234_567_890, -32'sd1_000_000_000, 32'h5555_5555, 32'hAAAA_AAAA
    };
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed values back to back
    foreach (directed[i]) send_value(directed[i]);
    wait_all_text();

    for (int n = 0; n < RANDOM_VALUES; n++) begin
      if (n == RANDOM_VALUES / 2) wait_all_text();
      if (burst_left == 0) begin
        burst_left = $urandom_range(8, 1);
        if ($urandom_range(3, 0) != 0) hold_off($urandom_range(20, 1));
      end
      send_value(pick_value());
      burst_left--;
    end

    wait_all_text();
    repeat (DRAIN_CYCLES) @(posedge clk);
    wrap_up <= 1'b1;
    @(posedge clk);
    wrap_up <= 1'b0;
    repeat (2) @(posedge clk);

    $display("converted %0d values (both extremes, zero, every digit count, both signs)",
             values_seen);
    $display("compared %0d output characters with their predicted text", chars_seen);
    if (fail_count == 0) begin
      $display("integer_to_decimal_ascii_core_test: PASS");
    end else begin
      $display("integer_to_decimal_ascii_core_test: FAIL");
    end
    $finish;
  end

endmodule
